// File: src/gpt_pkg.sv
`timescale 1ns / 1ps

package gpt_pkg;

  // One input transaction.
  typedef struct packed {
    logic               func;
    logic [9:0]         index_t;
    logic [9:0]         index_i;
    logic [9:0]         index_j;
    logic signed [47:0] cumsum_value;
    logic signed [47:0] cost_value;
    logic signed [47:0] optimal_cost;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic signed [47:0] test_value;
    logic               prune;
    logic               positive_mu;
    logic [1:0]         status;
  } result_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // Division slots, in the order they run.
  localparam logic [1:0] DV_MIT = 2'd0;
  localparam logic [1:0] DV_MJI = 2'd1;
  localparam logic [1:0] DV_CJI = 2'd2;
  localparam logic [1:0] DV_CIT = 2'd3;

  // Square operand select.
  localparam logic [1:0] SQ_MJI = 2'd0;
  localparam logic [1:0] SQ_MIT = 2'd1;
  localparam logic [1:0] SQ_G   = 2'd2;
  localparam logic [1:0] SQ_D   = 2'd3;

  localparam int IDX_X_W    = 17;  // index width that covers table depths up to 2^17 - 1
  localparam int DIV_NW     = 49;  // dividend magnitude width
  localparam int MUL_DIGITS = 3;   // 16-bit digits of a 48-bit operand

  localparam logic signed [47:0] V_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] V_MIN = 48'sh8000_0000_0000;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RD0   = 15'b000000000000010,
    S_RD1   = 15'b000000000000100,
    S_RD2   = 15'b000000000001000,
    S_RD3   = 15'b000000000010000,
    S_DIVS  = 15'b000000000100000,
    S_DIVW  = 15'b000000001000000,
    S_SQS   = 15'b000000010000000,
    S_SQW   = 15'b000000100000000,
    S_SQD   = 15'b000001000000000,
    S_SUMS  = 15'b000010000000000,
    S_CMP   = 15'b000100000000000,
    S_SQRTW = 15'b001000000000000,
    S_SQRTD = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  function automatic logic signed [49:0] sx50(input logic signed [47:0] v);
    sx50 = {{2{v[47]}}, v};
  endfunction

  function automatic logic ovf48(input logic signed [49:0] v);
    ovf48 = (v[49:47] != 3'b000) && (v[49:47] != 3'b111);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (ovf48(v)) begin
      sat48 = v[49] ? V_MIN : V_MAX;
    end else begin
      sat48 = v[47:0];
    end
  endfunction

  // Magnitude of a value known to lie in [-2^47, 2^47].
  function automatic logic [47:0] mag48(input logic signed [49:0] v);
    logic signed [49:0] a;
    a = v[49] ? -v : v;
    mag48 = a[47:0];
  endfunction

endpackage

// File: src/gpt_ram.sv
`timescale 1ns / 1ps

module gpt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/gpt_div.sv
`timescale 1ns / 1ps

module gpt_div #(
  parameter int NW = 49,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [DW:0]   rem_sh;
  logic          qbit;
  logic [DW:0]   rem_sub;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh  = {rem, quo[NW-1]};
  assign qbit    = rem_sh >= {1'b0, dv};
  assign rem_sub = rem_sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
        dv   <= den;
      end else if (busy) begin
        rem <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo <= {quo[NW-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/gaussian_pruning_test_1d.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+--------------------
// item     | in        | item_valid / item_ready     | gpt_pkg::item_t
// result   | out       | result_valid / result_ready | gpt_pkg::result_t
//
// A write transaction is taken while idle. An evaluate transaction with a bad
// index order goes straight to the finishing step. A valid evaluate runs four
// divisions in turn on the shared divider, and when mu is positive also the
// bit-serial square root.
// Reset is synchronous and clears the controller and the result valid; the
// tables hold garbage until written and need no clearing pass.
// A stalled result holds in its register while the next item is taken; only
// the finishing step of the next evaluate waits for it to drain.

module gaussian_pruning_test_1d #(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  gpt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output gpt_pkg::result_t result
);

  import gpt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [IDX_X_W-1:0] DEPTH_X = IDX_X_W'(TABLE_DEPTH);
  // Square root radicand width, rounded up to even.
  localparam int SQW      = 2 * ((47 + FRAC_BITS + 1) / 2);
  localparam int SQ_STEPS = SQW / 2;
  localparam int RMW      = SQ_STEPS + 3;
  localparam int SCW      = $clog2(SQ_STEPS);

  state_t state;

  // Latched transaction
  logic [AW-1:0]      t_ix, i_ix, j_ix, len, gap;
  logic signed [47:0] qt;
  logic               bad, sat_flag, pos;

  // Table entries
  logic signed [47:0] s_t, s_i, s_j, q_i, q_j;

  // Intermediates
  logic signed [47:0] m_it, m_ji, a_div, b_div;
  logic signed [47:0] sq_mji, sq_mit, g2, cji, cit, g, val;
  logic signed [49:0] d;
  logic [1:0]         dk, sel;

  // Memory ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, s_raddr, c_raddr;
  logic [47:0]        s_rd, c_rd;

  // Divider
  logic signed [49:0] div_src;
  logic [DIV_NW-1:0]  div_num, div_quo;
  logic [AW-1:0]      div_den;
  logic               div_start, div_done, div_neg;
  logic signed [49:0] div_q;
  logic signed [47:0] div_res;

  // Multiplier
  logic [47:0]        mul_a;
  logic [1:0]         mcnt;
  logic [95:0]        acc;
  logic [63:0]        prod;
  logic signed [49:0] sq_src;
  logic               sq_ovf;
  logic signed [47:0] sq_val;

  // Square root
  logic [SQW-1:0]     rad;
  logic [RMW-1:0]     rem, rem_sh, trial;
  logic [SQ_STEPS-1:0] root;
  logic [SCW-1:0]     scnt;

  // Accept / address decode
  logic               acc_in, order_ok;
  logic [IDX_X_W-1:0] tx;
  logic signed [49:0] gd, gabs, neg_cit, fin_sum;

  assign item_ready = (state == S_IDLE);
  assign acc_in     = item_valid && item_ready;
  assign tx         = IDX_X_W'(item.index_t);
  assign order_ok   = (item.index_j < item.index_i) && (item.index_i < item.index_t)
                      && (tx < DEPTH_X);

  // Write both tables at accept time.
  assign ram_we    = acc_in && (item.func == FUNC_WRITE) && (tx < DEPTH_X);
  assign ram_waddr = tx[AW-1:0];

  // Read schedule: S[t],Q[i] then S[i],Q[j] then S[j].
  always_comb begin
    case (state)
      S_RD0: begin
        s_raddr = t_ix;
        c_raddr = i_ix;
      end
      S_RD1: begin
        s_raddr = i_ix;
        c_raddr = j_ix;
      end
      default: begin
        s_raddr = j_ix;
        c_raddr = j_ix;
      end
    endcase
  end

  gpt_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_cumsum (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(item.cumsum_value),
    .raddr(s_raddr), .rdata(s_rd)
  );

  gpt_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_cost (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(item.cost_value),
    .raddr(c_raddr), .rdata(c_rd)
  );

  // Pick the numerator and length for the current division slot.
  always_comb begin
    case (dk)
      DV_MIT: begin
        div_src = sx50(s_t) - sx50(s_i);
        div_den = len;
      end
      DV_MJI: begin
        div_src = sx50(s_i) - sx50(s_j);
        div_den = gap;
      end
      DV_CJI: begin
        div_src = sx50(q_i) - sx50(q_j);
        div_den = gap;
      end
      default: begin
        div_src = sx50(qt) - sx50(q_i);
        div_den = len;
      end
    endcase
  end

  always_comb begin
    logic signed [49:0] dmag;
    dmag    = div_src[49] ? -div_src : div_src;
    div_num = dmag[DIV_NW-1:0];
  end

  assign div_start = (state == S_DIVS);
  assign div_q     = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign div_res   = sat48(div_q);

  gpt_div #(.NW(DIV_NW), .DW(AW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Square operand select.
  always_comb begin
    case (sel)
      SQ_MJI:  sq_src = sx50(m_ji);
      SQ_MIT:  sq_src = sx50(m_it);
      SQ_G:    sq_src = sx50(g);
      default: sq_src = d;
    endcase
  end

  // One 48x16 partial product per cycle.
  assign prod   = 64'(mul_a) * 64'(mul_a[{mcnt, 4'b0000} +: 16]);
  assign sq_ovf = |acc[95:47+FRAC_BITS];
  assign sq_val = sq_ovf ? V_MAX : {1'b0, acc[46+FRAC_BITS:FRAC_BITS]};

  // Square root: one root bit per cycle.
  assign rem_sh = {rem[RMW-3:0], rad[SQW-1:SQW-2]};
  assign trial  = RMW'({root, 2'b01});

  assign gd      = sx50(m_ji) - sx50(m_it);
  assign gabs    = gd[49] ? -gd : gd;
  assign neg_cit = -sx50(cit);
  assign fin_sum = neg_cit + sx50(sq_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in && item.func == FUNC_EVAL) begin
            t_ix     <= tx[AW-1:0];
            i_ix     <= AW'(IDX_X_W'(item.index_i));
            j_ix     <= AW'(IDX_X_W'(item.index_j));
            len      <= AW'(IDX_X_W'(item.index_t - item.index_i));
            gap      <= AW'(IDX_X_W'(item.index_i - item.index_j));
            qt       <= item.optimal_cost;
            bad      <= !order_ok;
            sat_flag <= 1'b0;
            pos      <= 1'b0;
            val      <= '0;
            state    <= order_ok ? S_RD0 : S_FIN;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          s_t   <= s_rd;
          q_i   <= c_rd;
          state <= S_RD2;
        end
        S_RD2: begin
          s_i   <= s_rd;
          q_j   <= c_rd;
          state <= S_RD3;
        end
        S_RD3: begin
          s_j   <= s_rd;
          dk    <= DV_MIT;
          state <= S_DIVS;
        end
        S_DIVS: begin
          div_neg <= div_src[49];
          state   <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            sat_flag <= sat_flag | ovf48(div_q);
            case (dk)
              DV_MIT:  m_it  <= div_res;
              DV_MJI:  m_ji  <= div_res;
              DV_CJI:  a_div <= div_res;
              default: b_div <= div_res;
            endcase
            if (dk == DV_CIT) begin
              sel   <= SQ_MJI;
              state <= S_SQS;
            end else begin
              dk    <= dk + 2'd1;
              state <= S_DIVS;
            end
          end
        end
        S_SQS: begin
          mul_a <= mag48(sq_src);
          acc   <= '0;
          mcnt  <= '0;
          state <= S_SQW;
        end
        S_SQW: begin
          acc  <= acc + (96'(prod) << {mcnt, 4'b0000});
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'(MUL_DIGITS - 1)) begin
            state <= S_SQD;
          end
        end
        S_SQD: begin
          sat_flag <= sat_flag | sq_ovf | ((sel == SQ_D) && ovf48(fin_sum));
          case (sel)
            SQ_MJI: begin
              sq_mji <= sq_val;
              sel    <= SQ_MIT;
              state  <= S_SQS;
            end
            SQ_MIT: begin
              sq_mit <= sq_val;
              state  <= S_SUMS;
            end
            SQ_G: begin
              g2    <= sq_val;
              state <= S_CMP;
            end
            default: begin
              // Positive mu: add the square of the root minus g to the negated cost term.
              val      <= sat48(fin_sum);
              state    <= S_FIN;
            end
          endcase
        end
        S_SUMS: begin
          cji      <= sat48(sx50(a_div) + sx50(sq_mji));
          cit      <= sat48(sx50(b_div) + sx50(sq_mit));
          g        <= sat48(gabs);
          sat_flag <= sat_flag | ovf48(sx50(a_div) + sx50(sq_mji))
                      | ovf48(sx50(b_div) + sx50(sq_mit)) | ovf48(gabs);
          sel      <= SQ_G;
          state    <= S_SQS;
        end
        S_CMP: begin
          if (cji <= g2) begin
            // Mu is zero: the value is the negated cost term.
            val      <= sat48(neg_cit);
            sat_flag <= sat_flag | ovf48(neg_cit);
            state    <= S_FIN;
          end else begin
            pos   <= 1'b1;
            rad   <= SQW'({cji[46:0], {FRAC_BITS{1'b0}}});
            rem   <= '0;
            root  <= '0;
            scnt  <= '0;
            state <= S_SQRTW;
          end
        end
        S_SQRTW: begin
          rad  <= {rad[SQW-3:0], 2'b00};
          scnt <= scnt + 1'b1;
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[SQ_STEPS-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[SQ_STEPS-2:0], 1'b0};
          end
          if (scnt == SCW'(SQ_STEPS - 1)) begin
            state <= S_SQRTD;
          end
        end
        S_SQRTD: begin
          d     <= $signed(50'(root)) - sx50(g);
          sel   <= SQ_D;
          state <= S_SQS;
        end
        S_FIN: begin
          // Hold until the previous result drains.
          if (!result_valid || result_ready) begin
            result.test_value  <= bad ? '0 : val;
            result.prune       <= !bad && (val > 0);
            result.positive_mu <= !bad && pos;
            result.status      <= bad ? ST_BAD : (sat_flag ? ST_SAT : ST_OK);
            result_valid       <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Table writes only happen while idle.
  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("table write outside idle");

  // The divider finishes only while the controller waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW)
    else $error("divider done out of sequence");

  // A bad index order reports a zero value and no prune.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_BAD |-> result.test_value == '0 && !result.prune)
    else $error("bad order result not cleared");

  // Prune follows the sign of the value.
  a_prune: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.prune == (result.test_value > 0))
    else $error("prune flag mismatch");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Scoreboard: holds the expected pruning results in order and checks each one.
class prune_scoreboard;
  gpt_pkg::result_t pending[$];
  int errors;

  // Note an accepted input transaction's expected result.
  function void note_item(gpt_pkg::result_t exp_res);
    pending.push_back(exp_res);
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(gpt_pkg::result_t got);
    gpt_pkg::result_t exp_res;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected result value=%0d", got.test_value));
      return;
    end
    exp_res = pending.pop_front();
    if (got.test_value !== exp_res.test_value)
      report_mismatch($sformatf("test_value got %0d exp %0d", got.test_value,
                                exp_res.test_value));
    if (got.prune !== exp_res.prune)
      report_mismatch($sformatf("prune got %0b exp %0b", got.prune, exp_res.prune));
    if (got.positive_mu !== exp_res.positive_mu)
      report_mismatch($sformatf("positive_mu got %0b exp %0b", got.positive_mu,
                                exp_res.positive_mu));
    if (got.status !== exp_res.status)
      report_mismatch($sformatf("status got %0d exp %0d", got.status, exp_res.status));
  endfunction

  function void report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endfunction
endclass

module tb;
  import gpt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int FRAC  = 16;
  localparam logic signed [63:0] MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -64'sh8000_0000_0000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // Idle rates in percent, changed per phase; hold_off freezes the receiver.
  int send_idle = 8;
  int recv_idle = 70;
  bit hold_off  = 1'b0;

  // Predictor copy of the two tables; written flags keep reads legal.
  logic signed [47:0] cumsum_mem[DEPTH];
  logic signed [47:0] cost_mem[DEPTH];
  bit                 written[DEPTH];
  int                 written_list[$];

  prune_scoreboard sb;

  gaussian_pruning_test_1d i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #10 clk = ~clk;

  // Saturate to 48 bits, raising the flag on clip.
  function automatic logic signed [63:0] clip48(logic signed [63:0] v, ref bit sat);
    if (v > MAX48) begin sat = 1; return MAX48; end
    if (v < MIN48) begin sat = 1; return MIN48; end
    return v;
  endfunction

  // Fixed-point square, truncated, clipped at the top.
  function automatic logic signed [63:0] square_q(logic signed [63:0] a, ref bit sat);
    logic [127:0] p;
    logic [63:0]  ua;
    ua = a < 0 ? -a : a;
    p = (ua * ua) >> FRAC;
    if (p > MAX48) begin sat = 1; return MAX48; end
    return p[63:0];
  endfunction

  // floor(sqrt(x << FRAC)), bit by bit.
  function automatic logic signed [63:0] root_q(logic signed [63:0] x);
    logic [127:0] v;
    logic [63:0]  c;
    logic [63:0]  r;
    v = {64'd0, x} << FRAC;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Work out the pruning test for one evaluate transaction.
  function automatic result_t predict_prune(item_t it);
    result_t r;
    bit sat;
    logic signed [63:0] len, gap, m_it, m_ji, cji, cit, g, g2, val, d;
    r = '0;
    sat = 0;
    if (!(it.index_j < it.index_i && it.index_i < it.index_t)) begin
      r.status = ST_BAD;
      return r;
    end
    len = 64'(it.index_t - it.index_i);
    gap = 64'(it.index_i - it.index_j);
    m_it = clip48((64'(cumsum_mem[it.index_t]) - cumsum_mem[it.index_i]) / len, sat);
    m_ji = clip48((64'(cumsum_mem[it.index_i]) - cumsum_mem[it.index_j]) / gap, sat);
    cji = clip48(clip48((64'(cost_mem[it.index_i]) - cost_mem[it.index_j]) / gap, sat)
                 + square_q(m_ji, sat), sat);
    cit = clip48(clip48((64'(it.optimal_cost) - cost_mem[it.index_i]) / len, sat)
                 + square_q(m_it, sat), sat);
    g = m_ji - m_it;
    if (g < 0) g = -g;
    g = clip48(g, sat);
    g2 = square_q(g, sat);
    if (cji <= g2) begin
      val = clip48(-cit, sat);
    end else begin
      d = root_q(cji) - g;
      val = clip48(-cit + square_q(d, sat), sat);
      r.positive_mu = 1'b1;
    end
    r.test_value = val[47:0];
    r.prune = val > 0;
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Update the predictor on an accepted input transaction.
  function automatic void absorb_item(item_t it);
    if (it.func == FUNC_WRITE) begin
      if (!written[it.index_t]) written_list.push_back(it.index_t);
      written[it.index_t] = 1;
      cumsum_mem[it.index_t] = it.cumsum_value;
      cost_mem[it.index_t] = it.cost_value;
    end else begin
      sb.note_item(predict_prune(it));
    end
  endfunction

  // Offer one transaction and hold it until accepted.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    absorb_item(it);
  endtask

  // Random 48-bit value: mostly modest, sometimes extreme.
  function automatic logic signed [47:0] rand_value();
    case ($urandom_range(9))
      0: return 48'({$urandom, $urandom});
      1: return $urandom_range(1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
      2: return {{16{1'b0}}, $urandom} - 48'sh0000_8000_0000;
      default: return $signed({{24{1'b0}}, 24'($urandom)}) - 48'sh0000_0080_0000;
    endcase
  endfunction

  task automatic write_entry(int idx, logic signed [47:0] cs, logic signed [47:0] cv);
    item_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.index_t = 10'(idx);
    it.index_i = 10'($urandom);
    it.index_j = 10'($urandom);
    it.cumsum_value = cs;
    it.cost_value = cv;
    it.optimal_cost = 48'({$urandom, $urandom});
    send_item(it);
  endtask

  task automatic eval_at(int t, int i, int j, logic signed [47:0] qt);
    item_t it;
    it = '0;
    it.func = FUNC_EVAL;
    it.index_t = 10'(t);
    it.index_i = 10'(i);
    it.index_j = 10'(j);
    it.cumsum_value = 48'({$urandom, $urandom});
    it.cost_value = 48'({$urandom, $urandom});
    it.optimal_cost = qt;
    send_item(it);
  endtask

  // Pick three written indices in order j < i < t.
  task automatic eval_random();
    int a, b, c, tmp;
    do begin
      a = written_list[$urandom_range(written_list.size() - 1)];
      b = written_list[$urandom_range(written_list.size() - 1)];
      c = written_list[$urandom_range(written_list.size() - 1)];
      if (a > b) begin tmp = a; a = b; b = tmp; end
      if (b > c) begin tmp = b; b = c; c = tmp; end
      if (a > b) begin tmp = a; a = b; b = tmp; end
    end while (!(a < b && b < c));
    eval_at(c, b, a, rand_value());
  endtask

  // Pick random indices that break the order j < i < t.
  task automatic eval_bad();
    int t, i, j;
    do begin
      t = $urandom_range(1023);
      i = $urandom_range(1023);
      j = $urandom_range(1023);
    end while (j < i && i < t);
    eval_at(t, i, j, rand_value());
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, and a long hold-off on request.
  always @(posedge clk) begin
    if (rst || hold_off) result_ready <= 1'b0;
    else result_ready <= $urandom_range(99) >= recv_idle;
  end

  // Check results on the accepting edge.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: edges of the tables, extreme values, and both cases.
    write_entry(0, 48'sh0, 48'sh0);
    write_entry(1, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000);
    write_entry(2, 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF);
    write_entry(1023, 48'sh0001_0000, 48'sh0000_8000);
    write_entry(10, 48'sh0003_0000, 48'sh0001_0000);
    write_entry(20, 48'sh0005_0000, 48'sh0002_0000);
    write_entry(30, 48'sh0014_0000, 48'sh0000_1000);
    eval_at(2, 1, 0, 48'sh7FFF_FFFF_FFFF);      // saturating means
    eval_at(1023, 2, 1, 48'sh8000_0000_0000);
    eval_at(20, 10, 0, 48'sh0003_0000);
    eval_at(30, 20, 10, 48'sh0000_0000);
    eval_at(30, 20, 10, 48'shFFFF_FFF0_0000);
    eval_at(5, 5, 1, 48'sh0);                   // bad order: i == t
    eval_at(3, 1, 1, 48'sh0);                   // bad order: j == i
    eval_at(0, 0, 0, 48'sh0);
    eval_at(1, 5, 9, 48'sh0);
    write_entry(1023, 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF);
    eval_at(1023, 30, 0, 48'sh7FFF_FFFF_FFFF);
    eval_at(1021, 1022, 1023, 48'({$urandom, $urandom})); // bad order check is cheap

    // Fill many entries so random evaluations have choices.
    for (int k = 0; k < 120; k++) write_entry($urandom_range(1023), rand_value(), rand_value());

    // Phase one: sender rarely idles, receiver often stalls.
    for (int k = 0; k < 300; k++) begin
      if ($urandom_range(3) == 0) write_entry($urandom_range(1023), rand_value(), rand_value());
      else if ($urandom_range(9) == 0) eval_bad();
      else eval_random();
    end

    // Long receiver hold-off while items keep coming; the block stalls input.
    hold_off = 1'b1;
    fork
      begin repeat (3000) @(posedge clk); hold_off = 1'b0; end
      for (int k = 0; k < 8; k++) eval_random();
    join
    drain();
    repeat (5) eval_random();
    drain();  // sender pauses until every result is back

    send_idle = 70;
    recv_idle = 8;
    for (int k = 0; k < 450; k++) begin
      if ($urandom_range(3) == 0) write_entry($urandom_range(1023), rand_value(), rand_value());
      else if ($urandom_range(9) == 0) eval_bad();
      else eval_random();
    end

    send_idle = 0;
    recv_idle = 0;
    for (int k = 0; k < 550; k++) begin
      if ($urandom_range(3) == 0) write_entry($urandom_range(1023), rand_value(), rand_value());
      else if ($urandom_range(9) == 0) eval_bad();
      else eval_random();
    end

    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: gaussian_pruning_test_1d.f
src/gpt_pkg.sv
src/gpt_ram.sv
src/gpt_div.sv
src/gaussian_pruning_test_1d.sv
test/tb.sv
